// ----- rtl/core/snav_pkg.sv -----
package snav_pkg;

    // Echo width to centimeters: floor(us / 58) as (us * CM_RECIP) >> CM_SHIFT.
    // Exact for every 14-bit echo width (error term stays below one count).
    localparam int unsigned ECHO_W    = 14;
    localparam int unsigned CM_SHIFT  = 20;
    localparam int unsigned RECIP_W   = 15;
    localparam logic [RECIP_W-1:0] CM_RECIP = 15'd18079;
    localparam int unsigned PROD_W    = ECHO_W + RECIP_W;

    localparam logic [8:0] MIN_GOOD_CM = 9'd2;
    localparam logic [8:0] MAX_GOOD_CM = 9'd200;
    localparam logic [7:0] START_CM    = 8'd80;

    localparam logic [9:0] STOP_WAIT_MS  = 10'd200;
    localparam logic [9:0] CHECK_WAIT_MS = 10'd350;
    localparam logic [9:0] ESCAPE_MS     = 10'd600;
    localparam logic [9:0] TIMER_MAX     = 10'd1023;

    // Navigation modes
    localparam logic [2:0] MODE_CRUISE      = 3'd0;
    localparam logic [2:0] MODE_STOP        = 3'd1;
    localparam logic [2:0] MODE_TURN_RIGHT  = 3'd2;
    localparam logic [2:0] MODE_CHECK_RIGHT = 3'd3;
    localparam logic [2:0] MODE_TURN_LEFT   = 3'd4;
    localparam logic [2:0] MODE_CHECK_LEFT  = 3'd5;
    localparam logic [2:0] MODE_UTURN       = 3'd6;
    localparam logic [2:0] MODE_ESCAPE      = 3'd7;

    // Configuration register indexes
    localparam logic [2:0] CFG_DANGER_CM   = 3'd0;
    localparam logic [2:0] CFG_CLEAR_CM    = 3'd1;
    localparam logic [2:0] CFG_DRIVE_SPEED = 3'd2;
    localparam logic [2:0] CFG_PIVOT_SPEED = 3'd3;
    localparam logic [2:0] CFG_LEFT_TRIM   = 3'd4;
    localparam logic [2:0] CFG_RIGHT_TRIM  = 3'd5;
    localparam logic [2:0] CFG_TURN_QUART  = 3'd6;
    localparam logic [2:0] CFG_TURN_HALF   = 3'd7;

    localparam logic [1:0] RING_LAST_SLOT = 2'd2;

    typedef logic signed [8:0] t_drive;

    function automatic logic [7:0] mid3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        logic [7:0] m;
        if ((a <= b && b <= c) || (c <= b && b <= a)) begin
            m = b;
        end else if ((b <= a && a <= c) || (c <= a && a <= b)) begin
            m = a;
        end else begin
            m = c;
        end
        return m;
    endfunction

    // Add trim to a nonzero speed and clamp to +/-255.
    function automatic t_drive trim_drive(logic [7:0] speed, logic signed [8:0] trim);
        logic signed [10:0] sum;
        t_drive             res;
        sum = $signed({3'b000, speed}) + $signed({{2{trim[8]}}, trim});
        if (speed == 8'd0) begin
            res = '0;
        end else if (sum > 11'sd255) begin
            res = 9'sd255;
        end else if (sum < -11'sd255) begin
            res = -9'sd255;
        end else begin
            res = sum[8:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/sonar_obstacle_avoid_nav_unit.sv -----
// Obstacle-avoidance navigator for a two-wheel robot. Each input word is one
// 1 ms tick; tuser[0] flags that the tick carries a sonar echo whose width in
// microseconds sits in tdata[13:0]. Echoes of 2..200 cm update the last good
// distance, others repeat it; the value is pushed into a 3-entry ring whose
// median is the filtered distance. An eight-mode sequencer (cruise, stop,
// turn right, check right, turn left half, check left, u-turn, escape) then
// produces signed wheel commands, one result word per tick. The block takes
// one word per cycle unless the output is stalled: a first stage converts the
// echo width to centimeters through a 14x15 reciprocal multiply, and a second
// stage updates the ring, median and mode state and loads the output register.
// There is no clearing pass after reset. Configuration registers may only be
// written while no tick is in flight.
module sonar_obstacle_avoid_nav_unit import snav_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [13:0] echo_us, [15:14] zero
    input  logic [0:0]  i_s_tuser,   // [0] echo_present
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [8:0] left_drive, [17:9] right_drive,
                                     // [20:18] nav_mode, [28:21] filtered_cm,
                                     // [31:29] zero
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [9:0]  i_cfg_wdata
);

    // ---------------- configuration registers ----------------
    logic [7:0]        r_danger_cm, r_clear_cm, r_drive_speed, r_pivot_speed;
    logic signed [8:0] r_left_trim, r_right_trim;
    logic [9:0]        r_turn_quart_ms, r_turn_half_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_danger_cm     <= 8'd12;
            r_clear_cm      <= 8'd22;
            r_drive_speed   <= 8'd155;
            r_pivot_speed   <= 8'd220;
            r_left_trim     <= -9'sd10;
            r_right_trim    <= 9'sd35;
            r_turn_quart_ms <= 10'd350;
            r_turn_half_ms  <= 10'd700;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DANGER_CM:   r_danger_cm     <= i_cfg_wdata[7:0];
                CFG_CLEAR_CM:    r_clear_cm      <= i_cfg_wdata[7:0];
                CFG_DRIVE_SPEED: r_drive_speed   <= i_cfg_wdata[7:0];
                CFG_PIVOT_SPEED: r_pivot_speed   <= i_cfg_wdata[7:0];
                CFG_LEFT_TRIM:   r_left_trim     <= $signed(i_cfg_wdata[8:0]);
                CFG_RIGHT_TRIM:  r_right_trim    <= $signed(i_cfg_wdata[8:0]);
                CFG_TURN_QUART:  r_turn_quart_ms <= i_cfg_wdata;
                CFG_TURN_HALF:   r_turn_half_ms  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline handshake ----------------
    // The output register frees up when empty or being taken; stage 1 then
    // advances into it, and stage 1 can refill in the same cycle.
    logic r_s1_valid, r_out_valid;
    logic out_open, s1_adv, in_acc;

    assign out_open   = !r_out_valid || i_m_tready;
    assign s1_adv     = r_s1_valid && out_open;
    assign o_s_tready = !r_s1_valid || out_open;
    assign in_acc     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- stage 1: echo width to centimeters ----------------
    logic [PROD_W-1:0] echo_prod;
    logic [8:0]        echo_cm;
    logic              r_s1_present, r_s1_good;
    logic [7:0]        r_s1_cm;

    assign echo_prod = PROD_W'(i_s_tdata[ECHO_W-1:0]) * PROD_W'(CM_RECIP);
    assign echo_cm   = echo_prod[PROD_W-1:CM_SHIFT];

    // Hold the stage while the output side is stalled.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_present <= i_s_tuser[0];
            // A timeout (width 0) yields 0 cm and so fails the range check.
            r_s1_good    <= (echo_cm >= MIN_GOOD_CM) && (echo_cm <= MAX_GOOD_CM);
            r_s1_cm      <= echo_cm[7:0];
        end
    end

    // ---------------- stage 2: filter and navigation state ----------------
    logic [7:0] r_ring [3];
    logic [1:0] r_slot;
    logic [7:0] r_last_good, r_median;
    logic [2:0] r_mode;
    logic [9:0] r_elapsed;

    logic [7:0] n_ring [3];
    logic [1:0] n_slot, cur_slot;
    logic [7:0] n_last_good, n_median;
    logic [2:0] n_mode;
    logic [9:0] n_elapsed, el;
    t_drive     n_left, n_right, piv;
    logic       danger, clear_ok;

    always_comb begin
        // ring update, only on ticks that carry an echo
        n_ring      = r_ring;
        n_slot      = r_slot;
        n_last_good = r_last_good;
        n_median    = r_median;
        cur_slot    = (r_slot > RING_LAST_SLOT) ? 2'd0 : r_slot;
        if (r_s1_present) begin
            if (r_s1_good) begin
                n_last_good = r_s1_cm;
            end
            n_ring[cur_slot] = n_last_good;
            n_slot   = (cur_slot == RING_LAST_SLOT) ? 2'd0 : cur_slot + 2'd1;
            n_median = mid3(n_ring[0], n_ring[1], n_ring[2]);
        end

        danger   = (n_median <= r_danger_cm);
        clear_ok = (n_median >= r_clear_cm);
        piv      = $signed({1'b0, r_pivot_speed});

        // saturating mode timer; entering a mode clears it
        el        = (r_elapsed != TIMER_MAX) ? r_elapsed + 10'd1 : r_elapsed;
        n_elapsed = el;
        n_mode    = r_mode;
        n_left    = '0;
        n_right   = '0;

        unique case (r_mode)
            MODE_CRUISE: begin
                if (danger) begin
                    n_mode    = MODE_STOP;
                    n_elapsed = '0;
                end else begin
                    n_left  = trim_drive(r_drive_speed, r_left_trim);
                    n_right = trim_drive(r_drive_speed, r_right_trim);
                end
            end
            MODE_STOP: begin
                if (el >= STOP_WAIT_MS) begin
                    n_mode    = MODE_TURN_RIGHT;
                    n_elapsed = '0;
                end
            end
            MODE_TURN_RIGHT: begin
                if (el >= r_turn_quart_ms) begin
                    n_mode    = MODE_CHECK_RIGHT;
                    n_elapsed = '0;
                end else begin
                    n_left  = piv;
                    n_right = -piv;
                end
            end
            MODE_CHECK_RIGHT: begin
                if (el >= CHECK_WAIT_MS) begin
                    n_mode    = clear_ok ? MODE_ESCAPE : MODE_TURN_LEFT;
                    n_elapsed = '0;
                end
            end
            MODE_TURN_LEFT: begin
                if (el >= r_turn_half_ms) begin
                    n_mode    = MODE_CHECK_LEFT;
                    n_elapsed = '0;
                end else begin
                    n_left  = -piv;
                    n_right = piv;
                end
            end
            MODE_CHECK_LEFT: begin
                if (el >= CHECK_WAIT_MS) begin
                    n_mode    = clear_ok ? MODE_ESCAPE : MODE_UTURN;
                    n_elapsed = '0;
                end
            end
            MODE_UTURN: begin
                if (el >= r_turn_quart_ms) begin
                    n_mode    = MODE_ESCAPE;
                    n_elapsed = '0;
                end else begin
                    n_left  = -piv;
                    n_right = piv;
                end
            end
            MODE_ESCAPE: begin
                if (danger) begin
                    n_mode    = MODE_STOP;
                    n_elapsed = '0;
                end else begin
                    // the tick that times out still drives forward
                    n_left  = trim_drive(r_drive_speed, r_left_trim);
                    n_right = trim_drive(r_drive_speed, r_right_trim);
                    if (el >= ESCAPE_MS) begin
                        n_mode    = MODE_CRUISE;
                        n_elapsed = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring[0]   <= START_CM;
            r_ring[1]   <= START_CM;
            r_ring[2]   <= START_CM;
            r_slot      <= 2'd0;
            r_last_good <= START_CM;
            r_median    <= START_CM;
            r_mode      <= MODE_CRUISE;
            r_elapsed   <= '0;
        end else if (s1_adv) begin
            r_ring      <= n_ring;
            r_slot      <= n_slot;
            r_last_good <= n_last_good;
            r_median    <= n_median;
            r_mode      <= n_mode;
            r_elapsed   <= n_elapsed;
        end
    end

    // ---------------- output register ----------------
    t_drive     r_out_left, r_out_right;
    logic [2:0] r_out_mode;
    logic [7:0] r_out_cm;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_left  <= n_left;
            r_out_right <= n_right;
            r_out_mode  <= n_mode;
            r_out_cm    <= n_median;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_cm, r_out_mode, r_out_right, r_out_left};

    // ---------------- assertions ----------------
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot != 2'd3)
        else $error("ring slot out of range");

    a_last_good_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last_good >= 8'd2 && r_last_good <= 8'd200)
        else $error("last good distance outside accepted band");

    a_median_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_median >= 8'd2 && r_median <= 8'd200)
        else $error("median outside accepted band");

    a_idle_wheels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_mode == MODE_STOP || r_out_mode == MODE_CHECK_RIGHT ||
                         r_out_mode == MODE_CHECK_LEFT))
        |-> (r_out_left == 9'sd0 && r_out_right == 9'sd0))
        else $error("wheels driven while stopped or checking");

    a_timer_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && n_mode != r_mode) |=> (r_elapsed == 10'd0))
        else $error("mode timer not cleared on mode change");

endmodule
